/* design/mexp_pkg.sv */
// shared constants, types and command/status structs for the modular exponentiation core
`timescale 1ns / 1ps

package mexp_pkg;

    // operand and result width
    localparam int unsigned DATA_W        = 32;
    // default number of exponent bits walked
    localparam int unsigned EXP_WIDTH_DEF = 32;
    // modulus after reset
    localparam logic [DATA_W-1:0] MODULUS_RESET = 32'd1000000007;

    // which register a reduced product goes back to
    typedef enum logic {
        TGT_ACC,
        TGT_X
    } tgt_t;

    // controller to datapath
    typedef struct packed {
        logic load;          // capture a new input beat
        logic mul;           // register x times (acc or x)
        logic red_start;     // start a reduction
        logic red_src_prod;  // reduce the product, else reduce x
        logic wr_en;         // write the remainder back
        tgt_t tgt;           // product operand and write-back target
        logic shift_e;       // step to the next exponent bit
        logic out_load;      // move acc into the output register
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic e_zero;        // exponent fully consumed
        logic e_bit0;        // current exponent bit
        logic e_last;        // no set bits above the current one
        logic red_done;      // remainder ready
    } dp_stat_t;

endpackage

/* design/mexp_red.sv */
// bit-serial remainder unit: 2W-bit dividend reduced by a (W+1)-bit modulus
`timescale 1ns / 1ps

module mexp_red (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [2*mexp_pkg::DATA_W-1:0]       dividend,
    input  logic [mexp_pkg::DATA_W:0]           divisor,
    output logic                                done,
    output logic [mexp_pkg::DATA_W-1:0]         rem
);
    import mexp_pkg::*;

    localparam int unsigned CNT_W = $clog2(DATA_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] low_reg, low_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;

    // one restoring step: the high half starts below the divisor, so W steps suffice
    assign trial = {rem_reg, low_reg[DATA_W-1]};
    assign diff  = trial - divisor;

    always_comb
    begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = dividend[2*DATA_W-1:DATA_W];
            low_next  = dividend[DATA_W-1:0];
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = (trial >= divisor) ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
            low_next = {low_reg[DATA_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // partial remainder and dividend shift line
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

/* design/mexp_dp.sv */
// datapath: modulus, accumulator, base, exponent, multiplier and output register
`timescale 1ns / 1ps

module mexp_dp #(
    parameter int unsigned EXP_WIDTH = mexp_pkg::EXP_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mexp_pkg::DATA_W-1:0]   cfg_data,
    input  logic [mexp_pkg::DATA_W-1:0]   base,
    input  logic [mexp_pkg::DATA_W-1:0]   exponent,
    input  mexp_pkg::dp_cmd_t             cmd,
    output mexp_pkg::dp_stat_t            stat,
    output logic [mexp_pkg::DATA_W-1:0]   power_result
);
    import mexp_pkg::*;

    logic [DATA_W-1:0]           mod_reg, mod_next;
    logic [DATA_W-1:0]           acc_reg, acc_next;
    logic [DATA_W-1:0]           x_reg, x_next;
    logic [EXP_WIDTH-1:0]        e_reg, e_next;
    logic [2*DATA_W-1:0]         prod_reg, prod_next;
    logic [DATA_W-1:0]           out_reg, out_next;

    logic [EXP_WIDTH+DATA_W-1:0] exp_ext;
    logic [DATA_W-1:0]           mul_b;
    logic [DATA_W:0]             divisor;
    logic [2*DATA_W-1:0]         dividend;
    logic                        red_done;
    logic [DATA_W-1:0]           red_rem;

    // a zero modulus stands for 2^W
    assign divisor = {(mod_reg == '0), mod_reg};

    // exponent cut or zero-extended to the walked width
    assign exp_ext = {{EXP_WIDTH{1'b0}}, exponent};

    // x times acc for a set bit, x times x for the squaring
    assign mul_b    = (cmd.tgt == TGT_ACC) ? acc_reg : x_reg;
    assign dividend = cmd.red_src_prod ? prod_reg : {{DATA_W{1'b0}}, x_reg};

    mexp_red u_red (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.red_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (red_done),
        .rem      (red_rem)
    );

    // next values
    always_comb
    begin
        mod_next  = cfg_we ? cfg_data : mod_reg;
        acc_next  = acc_reg;
        x_next    = x_reg;
        e_next    = e_reg;
        prod_next = prod_reg;
        out_next  = out_reg;
        if (cmd.load)
        begin
            acc_next = DATA_W'(1);
            x_next   = base;
            e_next   = exp_ext[EXP_WIDTH-1:0];
        end
        if (cmd.wr_en && cmd.tgt == TGT_ACC)
            acc_next = red_rem;
        if (cmd.wr_en && cmd.tgt == TGT_X)
            x_next = red_rem;
        if (cmd.shift_e)
            e_next = e_reg >> 1;
        if (cmd.mul)
            prod_next = {{DATA_W{1'b0}}, x_reg} * {{DATA_W{1'b0}}, mul_b};
        if (cmd.out_load)
            out_next = acc_reg;
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mod_reg <= MODULUS_RESET;
        else
            mod_reg <= mod_next;
    end

    // working registers
    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        x_reg    <= x_next;
        e_reg    <= e_next;
        prod_reg <= prod_next;
        out_reg  <= out_next;
    end

    // status to the controller
    assign stat.e_zero   = (e_reg == '0);
    assign stat.e_bit0   = e_reg[0];
    assign stat.e_last   = ((e_reg >> 1) == '0);
    assign stat.red_done = red_done;

    assign power_result = out_reg;

endmodule

/* design/mexp_ctrl.sv */
// controller: sequences square-and-multiply over the exponent bits
`timescale 1ns / 1ps

module mexp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  mexp_pkg::dp_stat_t   stat,
    output mexp_pkg::dp_cmd_t    cmd
);
    import mexp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_BIT,
        ST_SQ,
        ST_RSTART,
        ST_RWAIT,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    tgt_t   tgt_reg, tgt_next;
    logic   out_valid_reg, out_valid_next;

    // next state and commands
    always_comb
    begin
        cmd            = '0;
        cmd.tgt        = tgt_reg;
        state_next     = state_reg;
        tgt_next       = tgt_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            // zero exponent answers 1, else reduce the base first
            ST_CHECK:
            begin
                if (stat.e_zero)
                    state_next = ST_DONE;
                else
                begin
                    cmd.red_start = 1'b1;
                    cmd.tgt       = TGT_X;
                    tgt_next      = TGT_X;
                    state_next    = ST_RWAIT;
                end
            end
            // set bit: multiply the accumulator by x; clear bit: go straight to the squaring
            ST_BIT:
            begin
                if (stat.e_bit0)
                begin
                    cmd.mul    = 1'b1;
                    cmd.tgt    = TGT_ACC;
                    tgt_next   = TGT_ACC;
                    state_next = ST_RSTART;
                end
                else
                    state_next = ST_SQ;
            end
            // square x unless no set bits remain
            ST_SQ:
            begin
                if (stat.e_last)
                    state_next = ST_DONE;
                else
                begin
                    cmd.mul     = 1'b1;
                    cmd.shift_e = 1'b1;
                    cmd.tgt     = TGT_X;
                    tgt_next    = TGT_X;
                    state_next  = ST_RSTART;
                end
            end
            ST_RSTART:
            begin
                cmd.red_start    = 1'b1;
                cmd.red_src_prod = 1'b1;
                state_next       = ST_RWAIT;
            end
            ST_RWAIT:
            begin
                if (stat.red_done)
                begin
                    cmd.wr_en  = 1'b1;
                    state_next = (tgt_reg == TGT_ACC) ? ST_SQ : ST_BIT;
                end
            end
            // hand the result to the output register once it is free
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tgt_reg       <= TGT_ACC;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tgt_reg       <= tgt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* design/modular_exponentiation_core.sv */
// Sequence: for a zero exponent the input beat goes through the check state straight to the
// output register; otherwise the base is reduced first, and each set exponent bit and each
// squaring then waits on the one 32-step serial remainder unit.
// Throughput: one item at a time; a new beat is taken once the result is in the output register.
// Reset: rst_n clears the controller and loads the modulus with 1000000007.
`timescale 1ns / 1ps

module modular_exponentiation_core #(
    parameter int unsigned EXP_WIDTH = mexp_pkg::EXP_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mexp_pkg::DATA_W-1:0]   cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [mexp_pkg::DATA_W-1:0]   base,
    input  logic [mexp_pkg::DATA_W-1:0]   exponent,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mexp_pkg::DATA_W-1:0]   power_result
);
    import mexp_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer
    mexp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // arithmetic
    mexp_dp #(
        .EXP_WIDTH (EXP_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .base         (base),
        .exponent     (exponent),
        .cmd          (cmd),
        .stat         (stat),
        .power_result (power_result)
    );

endmodule

/* design/mexp_checker.sv */
// port-level checks for the modular exponentiation core
`timescale 1ns / 1ps

module mexp_port_checks (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cfg_we,
    input logic [mexp_pkg::DATA_W-1:0]   cfg_data,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic [mexp_pkg::DATA_W-1:0]   base,
    input logic [mexp_pkg::DATA_W-1:0]   exponent,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [mexp_pkg::DATA_W-1:0]   power_result
);
    import mexp_pkg::*;

    // a waiting result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(power_result))
        else $error("result beat changed while stalled");

    // one item at a time: busy right after an input beat
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in flight");

    // zero exponent answers 1 through the check and done states when the output is free
    a_zero_exp: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && exponent == '0 && !out_valid
        |-> ##3 (out_valid && power_result == DATA_W'(1)))
        else $error("zero exponent did not give 1");

    // a result only appears from a busy core
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result beat without an item in flight");

endmodule

bind modular_exponentiation_core mexp_port_checks u_mexp_port_checks (.*);

/* verif/mexp_checker.sv */
// scoreboard for the modular exponentiation core: predicts each power and compares result beats
`timescale 1ns / 1ps

module mexp_checker #(
    parameter int unsigned EXP_WIDTH = mexp_pkg::EXP_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mexp_pkg::DATA_W-1:0]   cfg_data,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [mexp_pkg::DATA_W-1:0]   base,
    input  logic [mexp_pkg::DATA_W-1:0]   exponent,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [mexp_pkg::DATA_W-1:0]   power_result,
    output int unsigned                   fail_count,
    output int unsigned                   pending
);

    import mexp_pkg::*;

    logic [DATA_W-1:0] modulus_q = MODULUS_RESET;
    logic [DATA_W-1:0] power_q[$];
    int unsigned       mismatches = 0;

    assign fail_count = mismatches;

    // one line per mismatch
    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("%0t ns: %s: got 0x%08h, want 0x%08h", $realtime, what, got, want);
        mismatches++;
    endtask

    // product of two operands, each reduced first, then the product reduced
    function automatic logic [63:0] mul_mod(input logic [63:0] a, input logic [63:0] b,
                                            input logic [63:0] m);
        logic [63:0] ra;
        logic [63:0] rb;
        ra = a % m;
        rb = b % m;
        return (ra * rb) % m;
    endfunction

    // right-to-left square-and-multiply over the low EXP_WIDTH exponent bits
    function automatic logic [DATA_W-1:0] predict_power(input logic [DATA_W-1:0] b,
                                                         input logic [DATA_W-1:0] e,
                                                         input logic [DATA_W-1:0] mod_reg);
        logic [63:0] m;
        logic [63:0] x;
        logic [63:0] acc;
        logic [63:0] e_bits;
        logic [63:0] e_mask;
        logic [63:0] res;
        // a zero modulus register stands for 2^32
        m = (mod_reg == '0) ? 64'h1_0000_0000 : {32'h0, mod_reg};
        e_mask = (EXP_WIDTH >= 64) ? '1 : ((64'd1 << EXP_WIDTH) - 64'd1);
        e_bits = {32'h0, e} & e_mask;
        // zero exponent gives 1 for every modulus, a modulus of one included
        if (e_bits == '0)
            return 1;
        acc = 64'd1;
        x = {32'h0, b};
        for (int i = 0; i < EXP_WIDTH && i < 64; i++)
        begin
            if (e_bits[0])
                acc = mul_mod(acc, x, m);
            x = mul_mod(x, x, m);
            e_bits = e_bits >> 1;
        end
        res = acc % m;
        return res[DATA_W-1:0];
    endfunction

    // watch the channels and the register port at every edge
    always @(posedge clk or negedge rst_n)
    begin : watch_beats
        logic [DATA_W-1:0] want;
        if (!rst_n)
        begin
            modulus_q = MODULUS_RESET;
            power_q.delete();
            pending <= 0;
        end
        else
        begin
            // result beat against the oldest expected power
            if (out_valid && out_ready)
            begin
                if (power_q.size() == 0)
                    report_mismatch("result beat with no power expected", power_result, '0);
                else
                begin
                    want = power_q.pop_front();
                    if (power_result !== want)
                        report_mismatch("power_result", power_result, want);
                end
            end
            // input beat uses the modulus in force before this edge
            if (in_valid && in_ready)
                power_q = {power_q, predict_power(base, exponent, modulus_q)};
            if (cfg_we)
                modulus_q = cfg_data;
            pending <= power_q.size();
        end
    end

endmodule

/* verif/tb_top.sv */
// top of the modular exponentiation testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;

    import mexp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int unsigned DRAIN_WAIT  = 2400;
    localparam int unsigned PHASE_ITEMS = 30;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [DATA_W-1:0] cfg_data;
    logic              in_valid;
    logic              in_ready;
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] exponent;
    logic              out_valid;
    logic              out_ready;
    logic [DATA_W-1:0] power_result;

    int unsigned       fail_count;
    int unsigned       pending;
    int unsigned       cycle_cnt = 0;
    logic [DATA_W-1:0] cur_modulus = MODULUS_RESET;
    bit                calm_phase = 1'b0;
    int unsigned       stall_left = 0;

    modular_exponentiation_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .base         (base),
        .exponent     (exponent),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .power_result (power_result)
    );

    mexp_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .base         (base),
        .exponent     (exponent),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .power_result (power_result),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // timeout
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d powers outstanding", cycle_cnt, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // idle length: mostly none or short, now and then long
    function automatic int unsigned idle_len();
        int unsigned pick;
        if (calm_phase)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 94)
            return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    // result side back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            stall_left <= idle_len();
        end
    end

    function automatic logic [DATA_W-1:0] rand_base();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 32'd1;
            2:       return '1;
            3:       return cur_modulus - 32'd1;
            4:       return cur_modulus * $urandom_range(1, 3);
            default: return $urandom;
        endcase
    endfunction

    // most exponents are short so the run stays quick
    function automatic logic [DATA_W-1:0] rand_exponent();
        int unsigned w;
        logic [63:0] e_mask;
        w = $urandom_range(1, DATA_W);
        e_mask = (64'd1 << w) - 64'd1;
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return 32'd1;
            2:       return '1;
            3:       return 32'h8000_0000 | $urandom;
            default: return $urandom & e_mask[DATA_W-1:0];
        endcase
    endfunction

    // one input beat, after a random gap
    task automatic send_beat(input logic [DATA_W-1:0] b, input logic [DATA_W-1:0] e);
        int unsigned gap;
        gap = idle_len();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        base <= b;
        exponent <= e;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // wait until every expected power has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_modulus(input logic [DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_data <= value;
        cur_modulus = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // stimulus
    initial
    begin
        logic [DATA_W-1:0] moduli[8];
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_data <= '0;
        in_valid <= 1'b0;
        base <= '0;
        exponent <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corners under the reset modulus
        send_beat(32'd0, 32'd0);
        send_beat(32'd0, 32'd1);
        send_beat(32'd0, '1);
        send_beat('1, 32'd0);
        send_beat(32'd1, '1);
        send_beat('1, '1);
        send_beat('1, 32'd1);
        send_beat(32'd2, 32'd31);
        send_beat(32'd2, 32'd32);
        send_beat(MODULUS_RESET, 32'd2);
        send_beat(MODULUS_RESET - 32'd1, '1);
        send_beat(32'hDEAD_BEEF, 32'h8000_0000);
        send_beat(32'd12345, 32'hAAAA_AAAA);
        send_beat(32'h8000_0000, 32'h5555_5555);
        send_beat(32'd3, 32'hFFFF_FFFE);
        send_beat(32'd7, 32'd2);
        drain();

        // modulus of one, all ones, two, zero (wraps at 2^32), a big prime, random, 13, back
        moduli = '{32'd1, 32'hFFFF_FFFF, 32'd2, 32'd0, 32'hFFFF_FFFB, $urandom, 32'd13,
                   MODULUS_RESET};
        foreach (moduli[p])
        begin
            write_modulus(moduli[p]);
            calm_phase = ($urandom_range(0, 3) == 0);
            send_beat($urandom, 32'd0);
            send_beat('1, '1);
            send_beat($urandom, 32'd1);
            repeat (PHASE_ITEMS) send_beat(rand_base(), rand_exponent());
            drain();
        end

        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
